>>> rtl/rgb_led_fade_timeout_controller_assert.svh
// Assertion helpers for the fade controller. Both sample on i_clk and are
// switched off while i_rst_n is low.
`ifndef RGB_LED_FADE_TIMEOUT_CONTROLLER_ASSERT_SVH
`define RGB_LED_FADE_TIMEOUT_CONTROLLER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RLFTC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RLFTC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/rlftc_pkg.sv
package rlftc_pkg;

    localparam int CHAN_W      = 6;
    localparam int DELTA_W     = 7;
    localparam int TIME_W      = 10;
    localparam int NODE_W      = 8;
    localparam int NUM_CHAN    = 3;
    // one integer quotient bit plus eight fraction bits: ratio 0..256
    localparam int RATIO_STEPS = 9;
    localparam int STEP_W      = $clog2(RATIO_STEPS);
    localparam int ACC_W       = CHAN_W + RATIO_STEPS - 1;

    typedef logic [CHAN_W-1:0]         t_chan;
    typedef logic signed [DELTA_W-1:0] t_delta;
    typedef logic [TIME_W-1:0]         t_time;

    typedef enum logic {
        OP_CMD  = 1'b0,
        OP_TICK = 1'b1
    } t_opcode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CALC,
        S_WRITE,
        S_POST,
        S_DONE
    } t_state;

    // shared control for the serial divider and the channel lanes
    typedef struct packed {
        logic load;
        logic step;
    } t_ser_ctrl;

endpackage

>>> rtl/rlftc_div.sv
module rlftc_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rlftc_pkg::t_ser_ctrl i_ctrl,
    input  rlftc_pkg::t_time    i_dividend,
    input  rlftc_pkg::t_time    i_divisor,
    output logic                o_qbit
);
    import rlftc_pkg::*;

    t_time               r_rem;
    logic                r_first;
    logic [TIME_W:0]     w_trial;

    // first step tests the integer bit, later ones shift in a zero
    assign w_trial = r_first ? {1'b0, r_rem} : {r_rem, 1'b0};
    assign o_qbit  = w_trial >= {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= 1'b0;
        end else if (i_ctrl.load) begin
            r_first <= 1'b1;
        end else if (i_ctrl.step) begin
            r_first <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_rem <= i_dividend;
        end else if (i_ctrl.step) begin
            if (o_qbit) begin
                r_rem <= TIME_W'(w_trial - {1'b0, i_divisor});
            end else begin
                r_rem <= w_trial[TIME_W-1:0];
            end
        end
    end

endmodule

>>> rtl/rlftc_lane.sv
module rlftc_lane (
    input  logic                 i_clk,
    input  rlftc_pkg::t_ser_ctrl i_ctrl,
    input  logic                 i_qbit,
    input  rlftc_pkg::t_delta    i_delta,
    input  rlftc_pkg::t_chan     i_start,
    output rlftc_pkg::t_chan     o_level
);
    import rlftc_pkg::*;

    logic [ACC_W-1:0] r_acc;
    t_chan            w_abs;
    t_chan            w_mag;

    assign w_abs = i_delta[DELTA_W-1] ? CHAN_W'(-i_delta) : i_delta[CHAN_W-1:0];

    // |delta| * ratio / 256, sign put back afterwards: truncates toward zero
    assign w_mag   = r_acc[ACC_W-1:ACC_W-CHAN_W];
    assign o_level = i_delta[DELTA_W-1] ? CHAN_W'(i_start - w_mag)
                                        : CHAN_W'(i_start + w_mag);

    // Horner accumulation over quotient bits, MSB first
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_acc <= '0;
        end else if (i_ctrl.step) begin
            r_acc <= {r_acc[ACC_W-2:0], 1'b0} + (i_qbit ? ACC_W'(w_abs) : ACC_W'(0));
        end
    end

endmodule

>>> rtl/rgb_led_fade_timeout_controller.sv
// RGB LED fade controller: each input item is either a colour command (four
// words, acted on only when the destination byte matches the node address)
// or one 10 ms tick, and every item returns exactly one result with the
// three 6-bit levels. A command goes straight to the result state; a tick
// with no fade running first passes the off-timer state, and a tick during a
// fade first runs the bit-serial ratio divider, which yields one quotient
// bit a cycle over 9 bits and feeds the three per-channel shift-add
// multipliers in step, then writes the levels and passes the off-timer
// state. The result state waits for the output register to be free. The
// input is stalled while an item is being worked on; the finished result
// sits in an output register, so the next item can be taken while it waits.
module rgb_led_fade_timeout_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_opcode,
    input  logic [15:0] i_cmd_word1,
    input  logic [15:0] i_cmd_word2,
    input  logic [15:0] i_cmd_word3,
    input  logic [15:0] i_cmd_word4,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [5:0]  o_red_level,
    output logic [5:0]  o_green_level,
    output logic [5:0]  o_blue_level
);
    import rlftc_pkg::*;

    t_state              r_state;
    t_state              n_state;
    t_ser_ctrl           w_ctrl;
    logic                w_in_stall;
    logic                w_out_load;

    logic [NODE_W-1:0]   r_node;
    t_chan               r_start [NUM_CHAN];
    t_delta              r_delta [NUM_CHAN];
    t_chan               r_cur   [NUM_CHAN];
    t_time               r_off;
    t_time               r_len;
    t_time               r_cnt;
    logic [STEP_W-1:0]   r_step;

    logic                r_out_valid;
    t_chan               r_red;
    t_chan               r_green;
    t_chan               r_blue;

    logic                w_in_acc;
    logic                w_out_free;
    logic                w_fade_act;
    logic                w_last;
    logic                w_match;
    logic                w_qbit;
    t_chan               w_lvl     [NUM_CHAN];
    t_chan               w_cmd_cur [NUM_CHAN];
    t_chan               w_cmd_tgt [NUM_CHAN];

    assign o_in_stall    = w_in_stall;
    assign o_out_valid   = r_out_valid;
    assign o_red_level   = r_red;
    assign o_green_level = r_green;
    assign o_blue_level  = r_blue;

    assign w_in_acc   = i_in_valid && !w_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_fade_act = (r_len != '0) && (r_cnt < r_len);
    assign w_last     = r_step == STEP_W'(RATIO_STEPS - 1);
    assign w_match    = i_cmd_word4[15:8] == r_node;

    assign w_cmd_cur[0] = i_cmd_word1[5:0];
    assign w_cmd_cur[1] = i_cmd_word1[11:6];
    assign w_cmd_cur[2] = {i_cmd_word2[1:0], i_cmd_word1[15:12]};
    assign w_cmd_tgt[0] = i_cmd_word2[7:2];
    assign w_cmd_tgt[1] = i_cmd_word2[13:8];
    assign w_cmd_tgt[2] = {i_cmd_word3[3:0], i_cmd_word2[15:14]};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (i_opcode == OP_TICK) begin
                        n_state = w_fade_act ? S_CALC : S_POST;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_CALC: begin
                if (w_last) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: n_state = S_POST;
            S_POST:  n_state = S_DONE;
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        w_in_stall  = 1'b1;
        w_ctrl      = '0;
        w_out_load  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                w_in_stall  = 1'b0;
                w_ctrl.load = i_in_valid && (i_opcode == OP_TICK) && w_fade_act;
            end
            S_CALC:  w_ctrl.step = 1'b1;
            S_WRITE: w_in_stall = 1'b1;
            S_POST:  w_in_stall = 1'b1;
            S_DONE:  w_out_load = w_out_free;
            default: w_in_stall = 1'b1;
        endcase
    end

    rlftc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (w_ctrl),
        .i_dividend (TIME_W'(r_cnt + 1'b1)),
        .i_divisor  (r_len),
        .o_qbit     (w_qbit)
    );

    for (genvar g = 0; g < NUM_CHAN; g++) begin : g_lane
        rlftc_lane u_lane (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_qbit  (w_qbit),
            .i_delta (r_delta[g]),
            .i_start (r_start[g]),
            .o_level (w_lvl[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node <= '0;
        end else if (i_cfg_wr_en) begin
            r_node <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '{default: '0};
            r_delta <= '{default: '0};
            r_cur   <= '{default: '0};
            r_off   <= '0;
            r_len   <= '0;
            r_cnt   <= '0;
            r_step  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_step <= '0;
                    if (w_in_acc) begin
                        if (i_opcode == OP_TICK) begin
                            if (w_fade_act) begin
                                r_cnt <= TIME_W'(r_cnt + 1'b1);
                            end
                        end else if (w_match) begin
                            for (int i = 0; i < NUM_CHAN; i++) begin
                                r_cur[i]   <= w_cmd_cur[i];
                                r_start[i] <= w_cmd_cur[i];
                                r_delta[i] <= DELTA_W'({1'b0, w_cmd_tgt[i]}
                                                       - {1'b0, w_cmd_cur[i]});
                            end
                            r_off <= i_cmd_word3[13:4];
                            r_len <= {i_cmd_word4[7:0], i_cmd_word3[15:14]};
                            r_cnt <= '0;
                        end
                    end
                end
                S_CALC: r_step <= STEP_W'(r_step + 1'b1);
                S_WRITE: begin
                    for (int i = 0; i < NUM_CHAN; i++) begin
                        r_cur[i] <= w_lvl[i];
                    end
                end
                S_POST: begin
                    // blanking wins over the fade value on the tick it fires
                    if (r_off != '0) begin
                        r_off <= TIME_W'(r_off - 1'b1);
                        if (r_off == TIME_W'(1)) begin
                            r_cur <= '{default: '0};
                        end
                    end
                end
                S_DONE:  r_step <= '0;
                default: r_step <= '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_red   <= r_cur[0];
            r_green <= r_cur[1];
            r_blue  <= r_cur[2];
        end
    end

`include "rgb_led_fade_timeout_controller_assert.svh"

    `RLFTC_ASSERT_SAME(a_cnt_in_range, 1'b1, r_cnt <= r_len, "fade count beyond fade length")
    `RLFTC_ASSERT_NEXT(a_fade_tick_calc, w_in_acc && (i_opcode == OP_TICK) && w_fade_act, r_state == S_CALC, "active fade tick did not start the ratio calculation")
    `RLFTC_ASSERT_SAME(a_step_bound, r_state == S_CALC, r_step < STEP_W'(RATIO_STEPS), "ratio step count overran")
    `RLFTC_ASSERT_NEXT(a_blank, (r_state == S_POST) && (r_off == TIME_W'(1)), (r_cur[0] == '0) && (r_cur[1] == '0) && (r_cur[2] == '0), "off timer expiry did not blank the channels")

endmodule
